// ===== rtl/ssx_pkg.sv =====
// ssx_pkg: shared types, codes and constants of the shadow silhouette extractor
// used by ssx_prim and shadow_silhouette_extractor; no dependencies
package ssx_pkg;

  localparam int MAX_FACES_DEF = 4096;
  localparam int FACE_FIELD_W  = 12;
  localparam int VCOUNT_W      = 15;
  localparam int IDX_W         = 16;
  localparam int CNT_W         = 16;
  localparam int APB_ADDR_W    = 4;
  localparam int APB_DATA_W    = 32;

  localparam logic [1:0] REQ_FLAG = 2'd0;
  localparam logic [1:0] REQ_EDGE = 2'd1;
  localparam logic [1:0] REQ_FACE = 2'd2;

  localparam logic [1:0] KIND_SIDE_QUAD = 2'd0;
  localparam logic [1:0] KIND_SIDE_TRI  = 2'd1;
  localparam logic [1:0] KIND_FRONT_CAP = 2'd2;
  localparam logic [1:0] KIND_BACK_CAP  = 2'd3;

  localparam logic [1:0] REG_INFINITE_LIGHT = 2'd0;
  localparam logic [1:0] REG_ZFAIL_CAPS     = 2'd1;
  localparam logic [1:0] REG_OPTIMIZE_BACK  = 2'd2;
  localparam logic [1:0] REG_VERTEX_COUNT   = 2'd3;

  typedef struct packed {
    logic [1:0]              req_type;
    logic                    first_of_mesh;
    logic [FACE_FIELD_W-1:0] face_a;
    logic [FACE_FIELD_W-1:0] face_b;
    logic                    has_face_b;
    logic                    facing;
    logic [IDX_W-1:0]        vert_a;
    logic [IDX_W-1:0]        vert_b;
    logic [IDX_W-1:0]        vert_c;
    logic                    opaque;
  } req_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] index_0;
    logic [IDX_W-1:0] index_1;
    logic [IDX_W-1:0] index_2;
    logic [IDX_W-1:0] index_3;
    logic [CNT_W-1:0] side_count;
    logic [CNT_W-1:0] front_count;
    logic [CNT_W-1:0] back_count;
    logic             last_of_item;
  } res_t;

  typedef struct packed {
    logic                infinite_light;
    logic                zfail_caps;
    logic                optimize_back_cap;
    logic [VCOUNT_W-1:0] vertex_count;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] sides;
    logic [CNT_W-1:0] fronts;
    logic [CNT_W-1:0] backs;
    logic [IDX_W-1:0] apex;
    logic             captured;
  } cnt_t;

endpackage

// ===== rtl/ssx_prim.sv =====
// ssx_prim: turns one item and its looked-up facing flags into up to two primitives
// and the next counter state; depends on ssx_pkg
module ssx_prim
  import ssx_pkg::*;
(
  input  req_t       item,
  input  logic       flag_a,
  input  logic       flag_b,
  input  cfg_t       cfg,
  input  cnt_t       cnt,
  output logic [1:0] count,
  output res_t       res_0,
  output res_t       res_1,
  output cnt_t       cnt_next
);

  cnt_t             base;
  logic             fa;
  logic             fb;
  logic [IDX_W-1:0] p;
  logic [IDX_W-1:0] q;
  logic [IDX_W-1:0] vc;
  logic [IDX_W-1:0] xp;
  logic [IDX_W-1:0] xq;

  assign vc = {1'b0, cfg.vertex_count};
  assign fa = flag_a;
  assign fb = item.has_face_b & flag_b;
  assign p  = fa ? item.vert_b : item.vert_a;
  assign q  = fa ? item.vert_a : item.vert_b;
  assign xp = vc + p;
  assign xq = vc + q;

  always_comb begin
    base = cnt;
    if (item.first_of_mesh) begin
      base.sides    = '0;
      base.fronts   = '0;
      base.backs    = '0;
      base.captured = 1'b0;
    end
    cnt_next = base;
    count    = 2'd0;
    res_0    = '0;
    res_1    = '0;
    unique case (item.req_type)
      REQ_EDGE: begin
        if (!base.captured) begin
          cnt_next.apex     = vc + item.vert_a;
          cnt_next.captured = 1'b1;
        end
        if (fa != fb) begin
          cnt_next.sides = base.sides + 1'b1;
          count = 2'd1;
          if (cfg.infinite_light) begin
            res_0.kind    = KIND_SIDE_TRI;
            res_0.index_0 = p;
            res_0.index_1 = q;
            res_0.index_2 = vc;
          end else begin
            res_0.kind    = KIND_SIDE_QUAD;
            res_0.index_0 = p;
            res_0.index_1 = q;
            res_0.index_2 = xq;
            res_0.index_3 = xp;
            if (cfg.zfail_caps && cfg.optimize_back_cap) begin
              count = 2'd2;
              cnt_next.backs = base.backs + 1'b1;
              res_1.kind    = KIND_BACK_CAP;
              res_1.index_0 = cnt_next.apex;
              res_1.index_1 = xp;
              res_1.index_2 = xq;
            end
          end
        end
      end
      REQ_FACE: begin
        if (cfg.zfail_caps && item.opaque) begin
          if (fa) begin
            count = 2'd1;
            cnt_next.fronts = base.fronts + 1'b1;
            res_0.kind    = KIND_FRONT_CAP;
            res_0.index_0 = item.vert_a;
            res_0.index_1 = item.vert_b;
            res_0.index_2 = item.vert_c;
          end else if (!cfg.infinite_light && !cfg.optimize_back_cap) begin
            count = 2'd1;
            cnt_next.backs = base.backs + 1'b1;
            res_0.kind    = KIND_BACK_CAP;
            res_0.index_0 = vc + item.vert_a;
            res_0.index_1 = vc + item.vert_b;
            res_0.index_2 = vc + item.vert_c;
          end
        end
      end
      default: begin
      end
    endcase
    res_0.side_count   = cnt_next.sides;
    res_0.front_count  = cnt_next.fronts;
    res_0.back_count   = (count == 2'd2) ? base.backs : cnt_next.backs;
    res_0.last_of_item = (count == 2'd1);
    res_1.side_count   = cnt_next.sides;
    res_1.front_count  = cnt_next.fronts;
    res_1.back_count   = cnt_next.backs;
    res_1.last_of_item = 1'b1;
  end

endmodule

// ===== rtl/shadow_silhouette_extractor.sv =====
// shadow_silhouette_extractor: top level with facing-flag memory, one work stage,
// output register and APB register file; depends on ssx_pkg and ssx_prim
//
// Usage: items arrive on req (valid/ready), primitives leave on res (valid/ready).
// Flag writes (type 0) store one facing bit per face in a synchronous flag memory;
// edges (type 1) and faces (type 2) read one or two flags there. The read is issued
// at the edge that accepts the item and its data is registered alongside the item
// in the work stage, so no forwarding is needed: one item is accepted per edge.
// A result is shown on res from the output register, which is fed by the work stage.
// Throughput: one item per cycle while the receiver does not stall; an edge
// that yields a side quad plus a back-cap fan triangle holds the work stage until
// both result words are emitted. Items with no result retire even while res stalls.
// Reset clears the counters, the fan apex capture, the configuration registers and
// all valid flags; the flag memory itself is not cleared and must be written
// before it is read. When the receiver stalls, the result stays in the output
// register, the work stage holds, and req_ready drops once both are full.
// The user must write configuration through APB only while the block is idle; the block does not enforce this.
module shadow_silhouette_extractor
  import ssx_pkg::*;
#(
  parameter int MAX_FACES = MAX_FACES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_t                  res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int FACE_W = $clog2(MAX_FACES);

  cfg_t              cfg;
  logic [1:0]        reg_sel;
  logic              cfg_write;

  logic              flag_mem [MAX_FACES];
  logic [FACE_W-1:0] addr_a;
  logic [FACE_W-1:0] addr_b;
  logic              flag_a;
  logic              flag_b;

  logic              accept;
  req_t              s1;
  logic              s1_valid;
  logic              s1_sub;
  cnt_t              cnt;
  cnt_t              cnt_next;
  logic [1:0]        count;
  res_t              res_0;
  res_t              res_1;
  logic              out_free;
  logic              emit;
  logic              retire;

  // configuration port
  assign pready    = 1'b1;
  assign reg_sel   = paddr[3:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_INFINITE_LIGHT: cfg.infinite_light    <= pwdata[0];
        REG_ZFAIL_CAPS:     cfg.zfail_caps        <= pwdata[0];
        REG_OPTIMIZE_BACK:  cfg.optimize_back_cap <= pwdata[0];
        REG_VERTEX_COUNT:   cfg.vertex_count      <= pwdata[VCOUNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_INFINITE_LIGHT: prdata[0] = cfg.infinite_light;
      REG_ZFAIL_CAPS:     prdata[0] = cfg.zfail_caps;
      REG_OPTIMIZE_BACK:  prdata[0] = cfg.optimize_back_cap;
      REG_VERTEX_COUNT:   prdata[VCOUNT_W-1:0] = cfg.vertex_count;
    endcase
  end

  // face slot in the flag memory
  generate
    if (FACE_W <= FACE_FIELD_W) begin : g_slot_trunc
      assign addr_a = req.face_a[FACE_W-1:0];
      assign addr_b = req.face_b[FACE_W-1:0];
    end else begin : g_slot_ext
      assign addr_a = {{(FACE_W-FACE_FIELD_W){1'b0}}, req.face_a};
      assign addr_b = {{(FACE_W-FACE_FIELD_W){1'b0}}, req.face_b};
    end
  endgenerate

  assign accept = req_valid & req_ready;

  // flag memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (accept) begin
      if (req.req_type == REQ_FLAG) begin
        flag_mem[addr_a] <= req.facing;
      end
      flag_a <= flag_mem[addr_a];
      flag_b <= flag_mem[addr_b];
    end
  end

  ssx_prim u_prim (
    .item     (s1),
    .flag_a   (flag_a),
    .flag_b   (flag_b),
    .cfg      (cfg),
    .cnt      (cnt),
    .count    (count),
    .res_0    (res_0),
    .res_1    (res_1),
    .cnt_next (cnt_next)
  );

  assign out_free  = !res_valid || res_ready;
  assign emit      = s1_valid && (count != 2'd0) && out_free;
  assign retire    = s1_valid && ((count == 2'd0) ||
                     (out_free && ({1'b0, s1_sub} == count - 2'd1)));
  assign req_ready = !s1_valid || retire;

  // work stage
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_sub   <= 1'b0;
      cnt      <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (retire) begin
        s1_valid <= 1'b0;
      end
      if (retire) begin
        s1_sub <= 1'b0;
        cnt    <= cnt_next;
      end else if (emit) begin
        s1_sub <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      res <= s1_sub ? res_1 : res_0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  a_second_word_needs_stage : assert property (@(posedge clk) disable iff (rst)
    s1_sub |-> s1_valid)
    else $error("second result word pending with an empty work stage");

  a_only_quad_continues : assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last_of_item |-> res.kind == KIND_SIDE_QUAD)
    else $error("non-final word that is not a side quad");

  a_fan_follows_quad : assert property (@(posedge clk) disable iff (rst)
    emit && s1_sub |-> res_valid && !res.last_of_item)
    else $error("fan triangle issued without its side quad ahead of it");

  a_empty_stage_ready : assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> req_ready)
    else $error("empty work stage refuses a word");

endmodule
